// File: rtl/lifs_pkg.sv
// shared types, constants and the row update function of the life automaton step block
// no dependencies
package lifs_pkg;

	localparam int ROWS    = 16;
	localparam int COLS    = 32;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int IDX_W   = 4;
	localparam int CELLS_W = 32;
	localparam int FUNC_W  = 2;
	localparam int COL_W   = 5;

	typedef logic [COLS-1:0] row_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR = 2'd0,
		FN_SET   = 2'd1,
		FN_STEP  = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic load_op;
		logic sweep;
	} cmd_t;

	typedef struct packed {
		logic last_row;
	} sts_t;

	// b3/s23 on one row, cells outside the board dead
	function automatic row_t next_row(row_t up, row_t cur, row_t down);
		row_t       res;
		logic [3:0] n;
		res = '0;
		for (int c = 0; c < COLS; c++) begin
			n = 4'(up[c]) + 4'(down[c]);
			if (c > 0) begin
				n = n + 4'(up[c-1]) + 4'(cur[c-1]) + 4'(down[c-1]);
			end
			if (c + 1 < COLS) begin
				n = n + 4'(up[c+1]) + 4'(cur[c+1]) + 4'(down[c+1]);
			end
			res[c] = (n == 4'd3) || (cur[c] && n == 4'd2);
		end
		return res;
	endfunction

endpackage

// File: rtl/lifs_ctrl.sv
// controller of the life automaton step block: operation sequencing and result handshake
// depends on lifs_pkg
module lifs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [lifs_pkg::FUNC_W-1:0] func,
	output logic                    out_valid,
	input  logic                    out_ready,
	output lifs_pkg::cmd_t          cmd,
	input  lifs_pkg::sts_t          sts
);

	lifs_pkg::state_t state_q, state_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;
	logic             accept;
	logic             is_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lifs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		slot_free   = !out_valid_q || out_ready;
		is_step     = (func == lifs_pkg::FN_STEP);
		in_ready    = (state_q == lifs_pkg::ST_IDLE) && slot_free;
		accept      = in_valid && in_ready;
		cmd.load_op = accept;
		cmd.sweep   = 1'b0;
		state_d     = state_q;
		case (state_q)
			lifs_pkg::ST_IDLE: begin
				if (accept && is_step) begin
					state_d = lifs_pkg::ST_SWEEP;
				end
			end
			lifs_pkg::ST_SWEEP: begin
				cmd.sweep = slot_free;
				if (slot_free && sts.last_row) begin
					state_d = lifs_pkg::ST_IDLE;
				end
			end
			default: state_d = lifs_pkg::ST_IDLE;
		endcase
		if ((accept && !is_step) || cmd.sweep) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
		out_valid = out_valid_q;
	end

endmodule

// File: rtl/lifs_dp.sv
// datapath of the life automaton step block: rotating board rows, row update, result register
// depends on lifs_pkg
module lifs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lifs_pkg::cmd_t               cmd,
	output lifs_pkg::sts_t               sts,
	input  logic [lifs_pkg::FUNC_W-1:0]  func,
	input  logic [lifs_pkg::IDX_W-1:0]   row,
	input  logic [lifs_pkg::COL_W-1:0]   col,
	input  logic                         value,
	output logic [lifs_pkg::IDX_W-1:0]   row_index,
	output logic [lifs_pkg::CELLS_W-1:0] row_cells,
	output logic                         last
);

	lifs_pkg::row_t                board_q [lifs_pkg::ROWS];
	lifs_pkg::row_t                upper_q;
	logic [lifs_pkg::ROW_W-1:0]    sweep_q;
	logic [lifs_pkg::IDX_W-1:0]    idx_q;
	logic [lifs_pkg::CELLS_W-1:0]  cells_q;
	logic                          last_q;
	lifs_pkg::row_t                down;
	lifs_pkg::row_t                new_row;
	lifs_pkg::row_t                rd_row;
	logic                          row_ok;
	logic                          col_ok;

	always_comb begin
		row_ok       = 32'(row) < lifs_pkg::ROWS;
		col_ok       = 32'(col) < lifs_pkg::COLS;
		rd_row       = row_ok ? board_q[lifs_pkg::ROW_W'(row)] : '0;
		sts.last_row = (sweep_q == lifs_pkg::ROW_W'(lifs_pkg::ROWS - 1));
		// row 1 of the rotated board is already the new row 0 at the bottom edge
		down         = sts.last_row ? '0 : board_q[1];
		new_row      = lifs_pkg::next_row(upper_q, board_q[0], down);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lifs_pkg::ROWS; i++) begin
				board_q[i] <= '0;
			end
			upper_q <= '0;
			sweep_q <= '0;
		end else if (cmd.load_op) begin
			case (lifs_pkg::func_t'(func))
				lifs_pkg::FN_CLEAR: begin
					for (int i = 0; i < lifs_pkg::ROWS; i++) begin
						board_q[i] <= '0;
					end
				end
				lifs_pkg::FN_SET: begin
					if (row_ok && col_ok) begin
						board_q[lifs_pkg::ROW_W'(row)][col] <= value;
					end
				end
				lifs_pkg::FN_STEP: begin
					upper_q <= '0;
					sweep_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.sweep) begin
			// rotate: old rows move up, the updated row enters at the bottom
			for (int i = 0; i < lifs_pkg::ROWS - 1; i++) begin
				board_q[i] <= board_q[i+1];
			end
			board_q[lifs_pkg::ROWS-1] <= new_row;
			upper_q <= board_q[0];
			sweep_q <= sts.last_row ? '0 : sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			last_q <= 1'b1;
			if (func == lifs_pkg::FN_READ) begin
				idx_q   <= row;
				cells_q <= lifs_pkg::CELLS_W'(rd_row);
			end else begin
				idx_q   <= '0;
				cells_q <= '0;
			end
		end else if (cmd.sweep) begin
			idx_q   <= lifs_pkg::IDX_W'(sweep_q);
			cells_q <= lifs_pkg::CELLS_W'(new_row);
			last_q  <= sts.last_row;
		end
	end

	assign row_index = idx_q;
	assign row_cells = cells_q;
	assign last      = last_q;

endmodule

// File: rtl/life_automaton_step.sv
// top level of the life automaton step block: stream ports, controller and datapath
// depends on lifs_pkg, lifs_ctrl, lifs_dp
//
// Bounded b3/s23 board of 16 rows by 32 columns, edges dead, no wrap. Clear, set and read take
// one beat in and give one beat out. A step is accepted and then sweeps the board row by row:
// the row update unit works on one row a cycle, all columns in parallel, and each new row
// leaves through the single result register as it is made, so a stalled output stalls the
// sweep. No input is taken while a step is running. Reset clears the board.
module life_automaton_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row[3:0], col[8:4], value[9], zero[15:10]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // row_index[3:0], row_cells[35:4], zero[39:36]
	output logic        m_tlast
);

	lifs_pkg::cmd_t                cmd;
	lifs_pkg::sts_t                sts;
	logic [lifs_pkg::IDX_W-1:0]    row_index;
	logic [lifs_pkg::CELLS_W-1:0]  row_cells;
	logic                          last;

	lifs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lifs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (s_tuser),
		.row       (s_tdata[3:0]),
		.col       (s_tdata[8:4]),
		.value     (s_tdata[9]),
		.row_index (row_index),
		.row_cells (row_cells),
		.last      (last)
	);

	assign m_tdata = {4'd0, row_cells, row_index};
	assign m_tlast = last;

endmodule

// File: sim/life_automaton_step_tb.sv
// self-checking testbench for life_automaton_step: directed and random clear/set/step/read beats
// under varying source idle and sink stall, with a scoreboard class predicting every result row
// depends on lifs_pkg and the life_automaton_step rtl
module life_automaton_step_tb;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [lifs_pkg::IDX_W-1:0]   idx;
		logic [lifs_pkg::CELLS_W-1:0] cells;
		logic                         last;
	} row_beat_t;

	class life_board_sb;
		lifs_pkg::row_t board[lifs_pkg::ROWS];
		row_beat_t      rows_q[$];
		int             errors;

		function new();
			errors = 0;
			foreach (board[r]) board[r] = '0;
		endfunction

		function void push_beat(int idx, lifs_pkg::row_t cells, logic last);
			row_beat_t b;
			b.idx   = lifs_pkg::IDX_W'(idx);
			b.cells = lifs_pkg::CELLS_W'(cells);
			b.last  = last;
			rows_q.push_back(b);
		endfunction

		// b3/s23 over the whole board, cells beyond the edges dead
		function void advance_generation();
			lifs_pkg::row_t prev[lifs_pkg::ROWS];
			int             n;
			prev = board;
			for (int r = 0; r < lifs_pkg::ROWS; r++) begin
				for (int c = 0; c < lifs_pkg::COLS; c++) begin
					n = 0;
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							if ((dr != 0 || dc != 0) && r + dr >= 0 &&
								r + dr < lifs_pkg::ROWS &&
								c + dc >= 0 && c + dc < lifs_pkg::COLS) begin
								n += prev[r+dr][c+dc];
							end
						end
					end
					board[r][c] = (n == 3) || (prev[r][c] && n == 2);
				end
			end
		endfunction

		function void note_op(lifs_pkg::func_t f, logic [3:0] r,
			logic [lifs_pkg::COL_W-1:0] c, logic v);
			case (f)
				lifs_pkg::FN_CLEAR: begin
					foreach (board[i]) board[i] = '0;
					push_beat(0, '0, 1'b1);
				end
				lifs_pkg::FN_SET: begin
					if (int'(r) < lifs_pkg::ROWS && int'(c) < lifs_pkg::COLS)
						board[r][c] = v;
					push_beat(0, '0, 1'b1);
				end
				lifs_pkg::FN_READ: begin
					push_beat(int'(r), (int'(r) < lifs_pkg::ROWS) ? board[r] :
						lifs_pkg::row_t'(0), 1'b1);
				end
				default: begin
					advance_generation();
					for (int i = 0; i < lifs_pkg::ROWS; i++)
						push_beat(i, board[i], i == lifs_pkg::ROWS - 1);
				end
			endcase
		endfunction

		function void check_row_beat(logic [lifs_pkg::IDX_W-1:0] idx,
			logic [lifs_pkg::CELLS_W-1:0] cells, logic last);
			row_beat_t e;
			if (rows_q.size() == 0) begin
				errors++;
				$display("%0t: expected no beat, got idx %0d cells %h last %b",
					$time, idx, cells, last);
				return;
			end
			e = rows_q.pop_front();
			if (e.idx !== idx || e.cells !== cells || e.last !== last) begin
				errors++;
				$display("%0t: mismatch expected idx %0d cells %h last %b, %s",
					$time, e.idx, e.cells, e.last,
					$sformatf("got idx %0d cells %h last %b", idx, cells, last));
			end
		endfunction

		function int pending();
			return rows_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // row[3:0], col[8:4], value[9], zero[15:10]
	logic [1:0]  s_tuser;  // func[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // row_index[3:0], row_cells[35:4], zero[39:36]
	logic        m_tlast;

	life_board_sb sb;
	int           snd_idle_pct;
	int           rcv_stall_pct;
	int           cycle_cnt;
	int           win_r;
	int           win_c;

	life_automaton_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result beats checked before the same edge's input beat is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_row_beat(m_tdata[3:0], m_tdata[35:4], m_tlast);
			if (s_tvalid && s_tready)
				sb.note_op(lifs_pkg::func_t'(s_tuser), s_tdata[3:0], s_tdata[8:4],
					s_tdata[9]);
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	task automatic send_op(lifs_pkg::func_t f, logic [3:0] r,
		logic [lifs_pkg::COL_W-1:0] c, logic v);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, v, c, r};
		s_tuser  <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic new_window();
		win_r = $urandom_range(lifs_pkg::ROWS - 4);
		win_c = $urandom_range(lifs_pkg::COLS - 8);
	endtask

	// sets cluster in a small window so steps see live structures
	task automatic send_random_op();
		int                         sel;
		logic [3:0]                 r;
		logic [lifs_pkg::COL_W-1:0] c;
		logic                       v;
		sel = $urandom_range(99);
		r   = 4'($urandom_range(15));
		c   = lifs_pkg::COL_W'($urandom_range(31));
		v   = 1'($urandom_range(1));
		if (sel < 52) begin
			if ($urandom_range(99) < 70) begin
				r = 4'(win_r + $urandom_range(3));
				c = lifs_pkg::COL_W'(win_c + $urandom_range(7));
				v = ($urandom_range(99) < 80);
			end
			send_op(lifs_pkg::FN_SET, r, c, v);
		end else if (sel < 75) begin
			send_op(lifs_pkg::FN_READ, r, c, v);
		end else if (sel < 94) begin
			send_op(lifs_pkg::FN_STEP, r, c, v);
			if ($urandom_range(3) == 0) new_window();
		end else begin
			send_op(lifs_pkg::FN_CLEAR, r, c, v);
			new_window();
		end
	endtask

	task automatic run_phase(int idle, int stall, int count, bit pause_mid);
		snd_idle_pct  = idle;
		rcv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (pause_mid && i == count / 2) wait_drained();
			send_random_op();
		end
	endtask

	initial begin
		sb            = new();
		cycle_cnt     = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		m_tready      = 1'b0;
		win_r         = 0;
		win_c         = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, edges, set to dead, block at a corner, blinker on the far edge
		send_op(lifs_pkg::FN_READ, 4'd0, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_SET, 4'd0, 5'd0, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd15, 5'd31, 1'b1);
		send_op(lifs_pkg::FN_READ, 4'd0, 5'd31, 1'b1);
		send_op(lifs_pkg::FN_READ, 4'd15, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_SET, 4'd0, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_SET, 4'd7, 5'd9, 1'b0);
		send_op(lifs_pkg::FN_READ, 4'd0, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_SET, 4'd0, 5'd0, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd0, 5'd1, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd1, 5'd0, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd1, 5'd1, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd15, 5'd29, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd15, 5'd30, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd8, 5'd15, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd8, 5'd16, 1'b1);
		send_op(lifs_pkg::FN_SET, 4'd8, 5'd17, 1'b1);
		send_op(lifs_pkg::FN_STEP, 4'd15, 5'd31, 1'b1);
		send_op(lifs_pkg::FN_STEP, 4'd0, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_READ, 4'd14, 5'd0, 1'b0);
		send_op(lifs_pkg::FN_CLEAR, 4'd15, 5'd31, 1'b1);
		send_op(lifs_pkg::FN_READ, 4'd15, 5'd31, 1'b1);
		send_op(lifs_pkg::FN_STEP, 4'd0, 5'd0, 1'b0);

		new_window();
		run_phase(0, 0, 32, 1'b0);
		run_phase(59, 0, 32, 1'b1);
		run_phase(0, 59, 32, 1'b0);
		run_phase(38, 38, 32, 1'b0);

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
